// ===== design/mfq_pkg.sv =====
// shared types, codes and default sizes for the multilevel fifo queue
`timescale 1ns / 1ps
`default_nettype none

package mfq_pkg;

	// default sizes
	localparam int MFQ_MAX_LEVELS  = 8;
	localparam int MFQ_LEVEL_DEPTH = 16;
	localparam int MFQ_ITEM_WIDTH  = 32;

	// port field widths
	localparam int LEVEL_W    = 3;
	localparam int ITEM_W     = 32;
	localparam int NUM_LVLS_W = 4;

	localparam logic [NUM_LVLS_W-1:0] NUM_LEVELS_RST = 4'd8;

	// operation codes
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2,
		STATUS_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_PTR,
		FSM_ENT,
		FSM_RESP
	} fsm_t;

	typedef struct packed {
		status_t             status;
		logic [LEVEL_W-1:0]  found_level;
		logic [ITEM_W-1:0]   item;
	} result_t;

endpackage

`default_nettype wire

// ===== design/multilevel_fifo_queue.sv =====
// Multilevel FIFO queue with rotating-priority dequeue, one item at a time.
// Out-of-range and empty requests are answered straight from the idle state; an enqueue
// passes through the pointer table read, a dequeue through the pointer table read and
// then the tag memory read. A new word is taken only once the previous one has reached
// the output register.
// Reset (arst_n low) clears control and pointer table valid bits, sets num_levels to 8.
`timescale 1ns / 1ps
`default_nettype none

module multilevel_fifo_queue
	import mfq_pkg::*;
#(
	parameter int MAX_LEVELS  = MFQ_MAX_LEVELS,
	parameter int LEVEL_DEPTH = MFQ_LEVEL_DEPTH,
	parameter int ITEM_WIDTH  = MFQ_ITEM_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  op,
	input  logic [LEVEL_W-1:0]    level,
	input  logic [ITEM_W-1:0]     item_in,
	// output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            status,
	output logic [LEVEL_W-1:0]    found_level,
	output logic [ITEM_W-1:0]     item_out,
	// configuration channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [NUM_LVLS_W-1:0] cfg_data
);

	localparam int LW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int HW    = $clog2(LEVEL_DEPTH);
	localparam int CW    = $clog2(LEVEL_DEPTH + 1);
	localparam int SW    = CW + 1;
	localparam int DEPTH = MAX_LEVELS * LEVEL_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	fsm_t                  state_q, state_d;
	logic [NUM_LVLS_W-1:0] num_levels_q;
	logic                  op_q;
	logic [LW-1:0]         tgt_q;
	logic [ITEM_W-1:0]     item_q;
	result_t               res_q, res_val, out_q;
	logic                  out_valid_q;

	logic                  in_accept, out_free, res_now, load_out;
	logic [5:0]            n_act;
	logic                  lvl_in_range;
	logic [LW-1:0]         lvl_idx;
	logic [MAX_LEVELS-1:0] nonempty, act_mask, hi_mask;
	logic                  hit_hi, hit_any;
	logic [LW-1:0]         idx_hi, idx_lo, deq_lvl;

	logic                  ptr_re, ptr_we;
	logic [LW-1:0]         ptr_raddr;
	logic [HW-1:0]         ptr_head, ptr_whead;
	logic [CW-1:0]         ptr_count, ptr_wcount;

	logic                  ent_we, ent_re;
	logic [AW-1:0]         ent_addr, base_addr, enq_addr, deq_addr;
	logic [ITEM_WIDTH-1:0] ent_wdata, ent_rdata;
	logic [63:0]           item_wide, ent_wide;
	logic [7:0]            tgt_wide;
	logic [SW-1:0]         slot_sum;
	logic [HW-1:0]         slot, head_next;
	logic                  level_full;

	assign in_stall  = (state_q != FSM_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// active level count and range check
	assign n_act = (6'(num_levels_q) > 6'(MAX_LEVELS)) ? 6'(MAX_LEVELS) : 6'(num_levels_q);
	assign lvl_in_range = (6'(level) < n_act);
	assign lvl_idx      = LW'(level);

	// rotating search: first non-empty level at or above start, else lowest
	always_comb begin
		hit_hi = 1'b0;
		idx_hi = '0;
		idx_lo = '0;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			act_mask[i] = nonempty[i] && (6'(i) < n_act);
			hi_mask[i]  = act_mask[i] && (6'(i) >= 6'(level));
		end
		for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
			if (hi_mask[i]) begin
				hit_hi = 1'b1;
				idx_hi = LW'(i);
			end
			if (act_mask[i]) begin
				idx_lo = LW'(i);
			end
		end
		hit_any = |act_mask;
		deq_lvl = hit_hi ? idx_hi : idx_lo;
	end

	// slot and address arithmetic
	assign base_addr  = AW'(tgt_q) * AW'(LEVEL_DEPTH);
	assign slot_sum   = SW'(ptr_head) + SW'(ptr_count);
	assign slot       = (slot_sum >= SW'(LEVEL_DEPTH)) ?
		HW'(slot_sum - SW'(LEVEL_DEPTH)) : HW'(slot_sum);
	assign enq_addr   = base_addr + AW'(slot);
	assign deq_addr   = base_addr + AW'(ptr_head);
	assign head_next  = (ptr_head == HW'(LEVEL_DEPTH - 1)) ? '0 : ptr_head + 1'b1;
	assign level_full = (ptr_count == CW'(LEVEL_DEPTH));

	// tag width conversion between ports and storage
	assign item_wide = 64'(item_q);
	assign ent_wdata = item_wide[ITEM_WIDTH-1:0];
	assign ent_wide  = 64'(ent_rdata);
	assign tgt_wide  = 8'(tgt_q);

	// sequencer next state and memory controls
	always_comb begin
		state_d    = state_q;
		ptr_re     = 1'b0;
		ptr_raddr  = lvl_idx;
		ptr_we     = 1'b0;
		ptr_whead  = ptr_head;
		ptr_wcount = ptr_count;
		ent_we     = 1'b0;
		ent_re     = 1'b0;
		ent_addr   = enq_addr;
		res_now    = 1'b0;
		res_val    = '0;
		unique case (state_q)
			FSM_IDLE: begin
				if (in_accept) begin
					priority if (!lvl_in_range) begin
						res_now        = 1'b1;
						res_val.status = STATUS_RANGE;
					end else if (op == OP_DEQ && !hit_any) begin
						res_now        = 1'b1;
						res_val.status = STATUS_EMPTY;
					end else begin
						ptr_re    = 1'b1;
						ptr_raddr = (op == OP_DEQ) ? deq_lvl : lvl_idx;
						state_d   = FSM_PTR;
					end
				end
			end
			FSM_PTR: begin
				if (op_q == OP_ENQ) begin
					res_now = 1'b1;
					if (level_full) begin
						res_val.status = STATUS_FULL;
					end else begin
						ent_we         = 1'b1;
						ent_addr       = enq_addr;
						ptr_we         = 1'b1;
						ptr_wcount     = ptr_count + 1'b1;
						res_val.status = STATUS_OK;
					end
				end else begin
					ent_re     = 1'b1;
					ent_addr   = deq_addr;
					ptr_we     = 1'b1;
					ptr_whead  = head_next;
					ptr_wcount = ptr_count - 1'b1;
					state_d    = FSM_ENT;
				end
			end
			FSM_ENT: begin
				res_now             = 1'b1;
				res_val.status      = STATUS_OK;
				res_val.found_level = tgt_wide[LEVEL_W-1:0];
				res_val.item        = ent_wide[ITEM_W-1:0];
			end
			FSM_RESP: begin
				if (out_free) begin
					state_d = FSM_IDLE;
				end
			end
		endcase
		if (res_now) begin
			state_d = out_free ? FSM_IDLE : FSM_RESP;
		end
	end

	assign load_out = out_free && (res_now || state_q == FSM_RESP);

	// state, config and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= FSM_IDLE;
			num_levels_q <= NUM_LEVELS_RST;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				num_levels_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// word registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q   <= op;
			tgt_q  <= (op == OP_DEQ) ? deq_lvl : lvl_idx;
			item_q <= item_in;
		end
		if (res_now && !out_free) begin
			res_q <= res_val;
		end
		if (load_out) begin
			out_q <= res_now ? res_val : res_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign found_level = out_q.found_level;
	assign item_out    = out_q.item;

	mfq_ptr_store #(
		.MAX_LEVELS  (MAX_LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH)
	) u_ptr_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.re       (ptr_re),
		.raddr    (ptr_raddr),
		.rd_head  (ptr_head),
		.rd_count (ptr_count),
		.we       (ptr_we),
		.waddr    (tgt_q),
		.wr_head  (ptr_whead),
		.wr_count (ptr_wcount),
		.nonempty (nonempty)
	);

	mfq_entry_ram #(
		.DEPTH (DEPTH),
		.WIDTH (ITEM_WIDTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_addr),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (ent_addr),
		.rdata (ent_rdata)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !load_out)
		else $error("output word overwritten while stalled");

	a_deq_level_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_PTR && op_q == OP_DEQ) |-> (ptr_count != '0))
		else $error("dequeue picked an empty level");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_IDLE) |-> (!ent_we && !ptr_we))
		else $error("memory write outside the pointer stage");

endmodule

`default_nettype wire

// ===== design/mfq_entry_ram.sv =====
// tag storage memory, one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module mfq_entry_ram
	import mfq_pkg::*;
#(
	parameter int DEPTH = MFQ_MAX_LEVELS * MFQ_LEVEL_DEPTH,
	parameter int WIDTH = MFQ_ITEM_WIDTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/mfq_ptr_store.sv =====
// per-level head and count memory with valid bits and non-empty flags
`timescale 1ns / 1ps
`default_nettype none

module mfq_ptr_store
	import mfq_pkg::*;
#(
	parameter int MAX_LEVELS  = MFQ_MAX_LEVELS,
	parameter int LEVEL_DEPTH = MFQ_LEVEL_DEPTH,
	localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1,
	localparam int HW = $clog2(LEVEL_DEPTH),
	localparam int CW = $clog2(LEVEL_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  re,
	input  logic [LW-1:0]         raddr,
	output logic [HW-1:0]         rd_head,
	output logic [CW-1:0]         rd_count,
	input  logic                  we,
	input  logic [LW-1:0]         waddr,
	input  logic [HW-1:0]         wr_head,
	input  logic [CW-1:0]         wr_count,
	output logic [MAX_LEVELS-1:0] nonempty
);

	logic [HW+CW-1:0]      mem [MAX_LEVELS];
	logic [MAX_LEVELS-1:0] valid_q;
	logic [MAX_LEVELS-1:0] nonempty_q;
	logic [HW+CW-1:0]      rdata_q;
	logic                  rvalid_q;

	// pointer memory write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wr_head, wr_count};
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// valid bits stand in for the all-zero reset of the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			nonempty_q <= '0;
			rvalid_q   <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr]    <= 1'b1;
				nonempty_q[waddr] <= (wr_count != '0);
			end
			if (re) begin
				rvalid_q <= valid_q[raddr];
			end
		end
	end

	// unwritten level reads as empty with head zero
	assign rd_head  = rvalid_q ? rdata_q[HW+CW-1:CW] : '0;
	assign rd_count = rvalid_q ? rdata_q[CW-1:0] : '0;
	assign nonempty = nonempty_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (wr_count <= CW'(LEVEL_DEPTH)))
		else $error("level count written beyond level depth");

	a_flag_tracks_write: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> (nonempty_q[$past(waddr)] == ($past(wr_count) != '0)))
		else $error("non-empty flag out of step with written count");

endmodule

`default_nettype wire

// ===== tb/sv/mfq_checker.sv =====
// checker for the multilevel fifo queue: predicts every response and compares it
`timescale 1ns / 1ps

module mfq_checker
	import mfq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  op,
	input  logic [LEVEL_W-1:0]    level,
	input  logic [ITEM_W-1:0]     item_in,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [1:0]            status,
	input  logic [LEVEL_W-1:0]    found_level,
	input  logic [ITEM_W-1:0]     item_out,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [NUM_LVLS_W-1:0] cfg_data,
	output int                    waiting,
	output int                    errors
);

	localparam int LEVELS = MFQ_MAX_LEVELS;
	localparam int DEPTH  = MFQ_LEVEL_DEPTH;

	// shadow copy of the per-level fifos
	logic [ITEM_W-1:0]     tag_store [LEVELS][DEPTH];
	int unsigned           head_at [LEVELS];
	int unsigned           fill [LEVELS];
	logic [NUM_LVLS_W-1:0] levels_cfg;
	result_t               response_q [$];

	// apply one word to the shadow fifos and return the response it should give
	function automatic result_t predict_response(input logic o, input logic [LEVEL_W-1:0] lvl,
			input logic [ITEM_W-1:0] tag);
		result_t     r;
		int unsigned active;
		int unsigned cur;
		r.status      = STATUS_OK;
		r.found_level = '0;
		r.item        = '0;
		active = (levels_cfg > LEVELS) ? LEVELS : levels_cfg;
		if (lvl >= active) begin
			r.status = STATUS_RANGE;
			return r;
		end
		if (o == OP_ENQ) begin
			if (fill[lvl] >= DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				tag_store[lvl][(head_at[lvl] + fill[lvl]) % DEPTH] = tag;
				fill[lvl]++;
			end
			return r;
		end
		// rotating search from the named level through the active ones
		cur = lvl;
		for (int k = 0; k < active; k++) begin
			if (fill[cur] != 0) begin
				r.found_level = LEVEL_W'(cur);
				r.item        = tag_store[cur][head_at[cur]];
				head_at[cur]  = (head_at[cur] + 1) % DEPTH;
				fill[cur]--;
				return r;
			end
			cur = (cur + 1 >= active) ? 0 : cur + 1;
		end
		r.status = STATUS_EMPTY;
		return r;
	endfunction

	// watch the three channels at every edge
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_at[i] = 0;
				fill[i]    = 0;
			end
			levels_cfg = NUM_LEVELS_RST;
			response_q.delete();
			errors  = 0;
			waiting <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				levels_cfg = cfg_data;
			// compare an accepted response word with the oldest prediction
			if (out_valid && !out_stall) begin
				if (response_q.size() == 0) begin
					$display("%0t: unexpected word: expected none, got status %0d level %0d item %h",
						$time, status, found_level, item_out);
					errors++;
				end else begin
					want = response_q.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %0d got %0d", $time, want.status, status);
						errors++;
					end
					if (found_level !== want.found_level) begin
						$display("%0t: found_level expected %0d got %0d",
							$time, want.found_level, found_level);
						errors++;
					end
					if (item_out !== want.item) begin
						$display("%0t: item_out expected %h got %h", $time, want.item, item_out);
						errors++;
					end
				end
			end
			// predict for an accepted request word
			if (in_valid && !in_stall)
				response_q.push_back(predict_response(op, level, item_in));
			waiting <= response_q.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the multilevel fifo queue testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
	import mfq_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic                  op        = OP_ENQ;
	logic [LEVEL_W-1:0]    level     = '0;
	logic [ITEM_W-1:0]     item_in   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [1:0]            status;
	logic [LEVEL_W-1:0]    found_level;
	logic [ITEM_W-1:0]     item_out;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [NUM_LVLS_W-1:0] cfg_data  = '0;

	int waiting;
	int errors;
	bit quiet      = 1'b0;
	int gap_pct    = 25;
	int stall_pct  = 20;
	int stall_left = 0;

	multilevel_fifo_queue dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.level      (level),
		.item_in    (item_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.found_level(found_level),
		.item_out   (item_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	mfq_checker mfq_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.level      (level),
		.item_in    (item_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.found_level(found_level),
		.item_out   (item_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.waiting    (waiting),
		.errors     (errors)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver stalls in random bursts
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(0, 3);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// send one request word, maybe after an idle burst
	task automatic send_word(input logic o, input logic [LEVEL_W-1:0] l,
			input logic [ITEM_W-1:0] tag);
		int gap;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		level    <= l;
		item_in  <= tag;
		do @(posedge clk); while (in_stall);
	endtask

	// stop sending and wait until every predicted response has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
	endtask

	// write the level count register while the block is idle
	task automatic write_levels(input logic [NUM_LVLS_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// one random phase under a given level count
	task automatic run_phase(input logic [NUM_LVLS_W-1:0] setting, input int count,
			input int enq_pct);
		int               active;
		logic             o;
		logic [LEVEL_W-1:0] l;
		drain();
		write_levels(setting);
		active = (setting > MFQ_MAX_LEVELS) ? MFQ_MAX_LEVELS : setting;
		gap_pct   = $urandom_range(0, 40);
		stall_pct = $urandom_range(0, 40);
		repeat (count) begin
			if (active == 0 || $urandom_range(0, 9) == 0) begin
				// noise: any level, either operation
				l = LEVEL_W'($urandom_range(0, 7));
				o = 1'($urandom_range(0, 1));
			end else begin
				// mostly in range, leaning on level 0 so it fills up
				l = ($urandom_range(0, 2) == 0) ? '0 : LEVEL_W'($urandom_range(0, active - 1));
				o = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
			end
			send_word(o, l, $urandom);
		end
	endtask

	// stimulus and verdict
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty structure from both ends
		send_word(OP_DEQ, 3'd0, 32'h0);
		send_word(OP_DEQ, 3'd7, 32'hFFFF_FFFF);
		// zero tag and all-ones tag, then a search that wraps
		send_word(OP_ENQ, 3'd0, 32'h0);
		send_word(OP_ENQ, 3'd7, 32'hFFFF_FFFF);
		send_word(OP_DEQ, 3'd7, 32'h0);
		send_word(OP_DEQ, 3'd3, 32'hFFFF_FFFF);
		// fill one level past its depth
		for (int i = 0; i <= MFQ_LEVEL_DEPTH; i++)
			send_word(OP_ENQ, 3'd2, {16'hA5C3, 16'(i)});

		// level 2 left behind, out of range on both operations
		drain();
		write_levels(4'd2);
		send_word(OP_DEQ, 3'd0, 32'h0);
		send_word(OP_ENQ, 3'd5, 32'h1234_5678);
		send_word(OP_DEQ, 3'd2, 32'h0);
		// no active levels at all
		drain();
		write_levels(4'd0);
		send_word(OP_ENQ, 3'd0, 32'h5A5A_5A5A);
		// count above the maximum is clamped, level 2 is reachable again
		drain();
		write_levels(4'd15);
		send_word(OP_DEQ, 3'd1, 32'h0);

		run_phase(4'd8, 130, 70);
		run_phase(4'd8, 90, 30);
		run_phase(4'd1, 70, 75);
		run_phase(4'd1, 40, 25);
		run_phase(4'd3, 90, 55);
		run_phase(4'd15, 90, 50);
		run_phase(4'd0, 20, 50);
		run_phase(NUM_LVLS_W'($urandom_range(1, 15)), 90, 50);
		quiet = 1'b1;
		run_phase(4'd5, 150, 45);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
design/mfq_pkg.sv
design/mfq_entry_ram.sv
design/mfq_ptr_store.sv
design/multilevel_fifo_queue.sv
tb/sv/mfq_checker.sv
tb/sv/testbench.sv
